// ===== rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants
// Request codes, status codes, sequencer states, config addresses and defaults.
// ----------------------------------------------------------------------------
package pst_pkg;
  localparam int SLOTS_DEF   = 4;
  localparam int BUTTONS_DEF = 32;
  localparam int TW          = 24;
  localparam int DW          = 20;
  localparam logic [TW-1:0] TIMER_MAX = {TW{1'b1}};

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0, REQ_CONN = 2'd1, REQ_PKT = 2'd2, REQ_DISC = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NONE = 2'd1, ST_STALE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_RD, S_WAIT, S_BTN, S_EMIT, S_CLR
  } state_t;

  localparam logic [1:0] A_EN    = 2'd0;
  localparam logic [1:0] A_FIRST = 2'd1;
  localparam logic [1:0] A_INTV  = 2'd2;
endpackage

// ===== rtl/pad_slot_tracker_with_key_repeat.sv =====
// ----------------------------------------------------------------------------
// pad_slot_tracker_with_key_repeat: remote pad slot table with key repeat
// Slot binding, sequenced key packets and typematic repeat per button.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one request; results leave on
// out_valid/out_stall, last marking the final result of a request.
// Connect, packet and disconnect search slots one per cycle and give one
// result; disconnect also sweeps the slot's timers. A tick walks every
// slot and button through the one timer unit and timer RAM: read, read
// wait and write back per button, with one result per slot.
// A new request is taken only after the last result transfer of the
// previous one.
// Reset clears all slots; the timer RAM is cleared by a pass of one cycle
// per RAM word (SLOTS*BUTTONS at the default sizes), during which in_stall
// is high.
// When the receiver stalls, the result holds, a tick waits at its next
// result and no new request is taken.
// Configuration writes go through the cfg_ APB port; the user is to write only when idle, not enforced by the block.
// ----------------------------------------------------------------------------
module pad_slot_tracker_with_key_repeat
  import pst_pkg::*;
#(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int BUTTONS = BUTTONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_client_id,
  input  logic [31:0] in_sequence_req,
  input  logic [31:0] in_key_bits,
  input  logic [15:0] in_elapsed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_slot,
  output logic        out_slot_active,
  output logic [31:0] out_buttons_now,
  output logic [31:0] out_buttons_prev,
  output logic [31:0] out_buttons_repeat,
  output logic [31:0] out_raw_now,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int AW = SW + BW;
  localparam int DEPTH = 1 << AW;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [BUTTONS-1:0] BM = {BUTTONS{1'b1}};

  logic          en_r;
  logic [DW-1:0] first_r, intv_r;
  logic          cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      first_r <= DW'(8000);
      intv_r <= DW'(1600);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        A_EN:    en_r <= cfg_pwdata[0];
        A_FIRST: first_r <= cfg_pwdata[DW-1:0];
        A_INTV:  intv_r <= cfg_pwdata[DW-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (cfg_paddr[3:2])
      A_EN:    cfg_prdata = {31'd0, en_r};
      A_FIRST: cfg_prdata = {{(32-DW){1'b0}}, first_r};
      A_INTV:  cfg_prdata = {{(32-DW){1'b0}}, intv_r};
      default: cfg_prdata = '0;
    endcase
  end

  logic [SLOTS-1:0]   act_r;
  logic [31:0]        id_r [SLOTS];
  logic [31:0]        seq_r [SLOTS];
  logic [BUTTONS-1:0] held_r [SLOTS];
  logic [BUTTONS-1:0] prior_r [SLOTS];
  logic [BUTTONS-1:0] once_r [SLOTS];
  logic [BUTTONS-1:0] fire_r [SLOTS];

  state_t        st_r, st_nxt;
  req_t          req_r;
  logic [31:0]   cid_r, cseq_r;
  logic [BUTTONS-1:0] keys_r, fire_acc_r;
  logic [15:0]   el_r;
  logic [SW-1:0] s_r;
  logic [BW-1:0] b_r;
  logic [CW-1:0] clr_r;

  logic          ov_r;
  logic [1:0]    o_slot_r, o_status_r;
  logic          o_act_r, o_last_r;
  logic [31:0]   o_now_r, o_prev_r, o_rep_r, o_raw_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [TW-1:0] ram_wd, ram_rd;
  logic [TW-1:0] t_nxt;
  logic          t_fire, t_once;

  pst_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  pst_timer_unit u_tu (
    .timer(ram_rd), .elapsed(el_r), .held(held_r[s_r][b_r]),
    .prior(prior_r[s_r][b_r]), .once(once_r[s_r][b_r]),
    .first_delay(first_r), .interval(intv_r),
    .timer_nxt(t_nxt), .fire(t_fire), .once_nxt(t_once)
  );

  logic in_acc, out_acc, s_last, b_last, hit_conn, hit_act;
  assign in_stall = (st_r != S_IDLE) || ov_r || (clr_r != '0);
  assign in_acc = in_valid && !in_stall;
  assign out_acc = ov_r && !out_stall;
  assign out_valid = ov_r;
  assign s_last = (s_r == SW'(SLOTS - 1));
  assign b_last = (b_r == BW'(BUTTONS - 1));
  assign hit_conn = (id_r[s_r] == cid_r) || !act_r[s_r];
  assign hit_act = act_r[s_r] && (id_r[s_r] == cid_r);

  logic [AW-1:0] cur_addr;
  assign cur_addr = {s_r, b_r};

  always_comb begin
    st_nxt = st_r;
    ram_we = 1'b0;
    ram_addr = cur_addr;
    ram_wd = '0;
    unique case (st_r)
      S_IDLE: if (in_acc) st_nxt = (in_req_type == REQ_TICK) ? S_RD : S_SRCH;
      S_SRCH: begin
        if ((req_r == REQ_CONN) ? hit_conn : hit_act) begin
          st_nxt = (req_r == REQ_DISC) ? S_CLR : S_EMIT;
        end else if (s_last) begin
          st_nxt = S_EMIT;
        end
      end
      S_RD:   st_nxt = S_WAIT;
      S_WAIT: st_nxt = S_BTN;
      S_BTN: begin
        ram_we = 1'b1;
        ram_wd = t_nxt;
        st_nxt = b_last ? S_EMIT : S_RD;
      end
      S_EMIT: if (!ov_r) st_nxt = (req_r == REQ_TICK && !s_last) ? S_RD : S_IDLE;
      S_CLR: begin
        ram_we = 1'b1;
        st_nxt = b_last ? S_EMIT : S_CLR;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (clr_r != '0) begin
      ram_we = 1'b1;
      ram_addr = AW'(clr_r - 1'b1);
      ram_wd = '0;
    end
  end

  logic found_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      clr_r <= CW'(DEPTH);
      act_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        id_r[i] <= '0; seq_r[i] <= '0; held_r[i] <= '0;
        prior_r[i] <= '0; once_r[i] <= '0; fire_r[i] <= '0;
      end
    end else begin
      st_r <= (clr_r != '0) ? S_IDLE : st_nxt;
      if (clr_r != '0) clr_r <= clr_r - 1'b1;
      if (out_acc) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_acc && clr_r == '0) begin
          req_r <= req_t'(in_req_type);
          cid_r <= in_client_id;
          cseq_r <= in_sequence_req;
          keys_r <= in_key_bits[BUTTONS-1:0] & BM;
          el_r <= in_elapsed;
          s_r <= '0; b_r <= '0;
          fire_acc_r <= '0;
          found_r <= 1'b0;
        end
        S_SRCH: begin
          if ((req_r == REQ_CONN) ? hit_conn : hit_act) begin
            found_r <= 1'b1;
            unique case (req_r)
              REQ_CONN: begin
                act_r[s_r] <= 1'b1; id_r[s_r] <= cid_r; seq_r[s_r] <= '0;
              end
              REQ_PKT: if (seq_r[s_r] < cseq_r) begin
                held_r[s_r] <= keys_r; seq_r[s_r] <= cseq_r;
              end
              default: begin
                act_r[s_r] <= 1'b0; id_r[s_r] <= '0; seq_r[s_r] <= '0;
                held_r[s_r] <= '0; prior_r[s_r] <= '0;
                once_r[s_r] <= '0; fire_r[s_r] <= '0;
              end
            endcase
          end else if (!s_last) begin
            s_r <= s_r + 1'b1;
          end
          if (req_r == REQ_PKT && hit_act && !(seq_r[s_r] < cseq_r))
            o_status_r <= ST_STALE;
          else
            o_status_r <= ST_OK;
        end
        S_BTN: begin
          fire_acc_r[b_r] <= t_fire;
          once_r[s_r][b_r] <= t_once;
          if (!b_last) b_r <= b_r + 1'b1;
        end
        S_CLR: if (!b_last) b_r <= b_r + 1'b1;
        S_EMIT: if (!ov_r) begin
          ov_r <= 1'b1;
          if (req_r == REQ_TICK) begin
            o_slot_r <= 2'(s_r);
            o_act_r <= act_r[s_r];
            o_now_r <= en_r ? 32'(held_r[s_r]) : '0;
            o_prev_r <= en_r ? 32'(prior_r[s_r]) : '0;
            o_rep_r <= en_r ? 32'(fire_acc_r) : '0;
            o_raw_r <= 32'(held_r[s_r]);
            o_status_r <= ST_OK;
            o_last_r <= s_last;
            fire_r[s_r] <= fire_acc_r;
            prior_r[s_r] <= held_r[s_r];
            fire_acc_r <= '0;
            b_r <= '0;
            if (!s_last) s_r <= s_r + 1'b1;
          end else begin
            o_last_r <= 1'b1;
            if (found_r) begin
              o_slot_r <= 2'(s_r);
              o_act_r <= act_r[s_r];
              o_now_r <= en_r ? 32'(held_r[s_r]) : '0;
              o_prev_r <= en_r ? 32'(prior_r[s_r]) : '0;
              o_rep_r <= en_r ? 32'(fire_r[s_r]) : '0;
              o_raw_r <= 32'(held_r[s_r]);
            end else begin
              o_slot_r <= '0; o_act_r <= 1'b0; o_now_r <= '0;
              o_prev_r <= '0; o_rep_r <= '0; o_raw_r <= '0;
              o_status_r <= ST_NONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_slot = o_slot_r;
  assign out_slot_active = o_act_r;
  assign out_buttons_now = o_now_r;
  assign out_buttons_prev = o_prev_r;
  assign out_buttons_repeat = o_rep_r;
  assign out_raw_now = o_raw_r;
  assign out_status = o_status_r;
  assign out_last = o_last_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(o_slot_r))) else $error("result lost");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_status_r == ST_NONE) |-> (o_raw_r == '0 && o_last_r))
    else $error("empty result not clean");
endmodule

// ===== rtl/pst_ram.sv =====
// ----------------------------------------------------------------------------
// pst_ram: generic single-port RAM
// One access per cycle, registered read data (old contents on a write).
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/pst_timer_unit.sv =====
// ----------------------------------------------------------------------------
// pst_timer_unit: shared per-button repeat step
// Saturating add, limit compare and subtract for one button timer.
// ----------------------------------------------------------------------------
module pst_timer_unit
  import pst_pkg::*;
(
  input  logic [TW-1:0] timer,
  input  logic [15:0]   elapsed,
  input  logic          held,
  input  logic          prior,
  input  logic          once,
  input  logic [DW-1:0] first_delay,
  input  logic [DW-1:0] interval,
  output logic [TW-1:0] timer_nxt,
  output logic          fire,
  output logic          once_nxt
);
  logic [TW:0]   sum;
  logic [TW-1:0] sat, lim;
  always_comb begin
    sum = {1'b0, timer} + {{(TW-15){1'b0}}, elapsed};
    sat = sum[TW] ? TIMER_MAX : sum[TW-1:0];
    lim = once ? {{(TW-DW){1'b0}}, interval} : {{(TW-DW){1'b0}}, first_delay};
    timer_nxt = '0;
    fire = 1'b0;
    once_nxt = 1'b0;
    if (held) begin
      timer_nxt = sat;
      once_nxt = once;
      if (!prior) begin
        fire = 1'b1;
      end else if (sat > lim) begin
        fire = 1'b1;
        once_nxt = 1'b1;
        timer_nxt = sat - lim;
      end
    end
  end
endmodule
